>>> rtl/gsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared constants, codes and control structs for the suffix automaton block.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int SYMBOLS    = 26;
    localparam int NODE_W     = 12;
    localparam int LEN_W      = 13;
    localparam int SYM_W      = 5;
    localparam int CNT_W      = 13;
    localparam int EDGE_DEPTH = MAX_NODES * SYMBOLS;
    localparam int EADDR_W    = $clog2(EDGE_DEPTH);

    localparam logic CMD_EXTEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_RD_IN, S_CHK_IN, S_RD_T, S_CHK_T, S_CLR,
        S_L1_RD, S_L1_CHK, S_Q_RD, S_Q_CHK, S_COPY_RD, S_COPY_WR,
        S_FIX1, S_FIX2, S_L2_RD, S_L2_CHK, S_RES_RD, S_RES_CHK, S_OUT
    } t_state;

    typedef enum logic [2:0] {RD_NODE, RD_T, RD_P, RD_Q, RD_RES} t_rd_sel;
    typedef enum logic [2:0] {EW_NONE, EW_CLR, EW_LINK1, EW_COPY, EW_LINK2} t_ew;
    typedef enum logic [1:0] {LW_NONE, LW_INIT, LW_NP, LW_NQ} t_lw;
    typedef enum logic [2:0] {
        SW_NONE, SW_INIT, SW_NP_ONE, SW_NP_Q, SW_NQ_SQ, SW_Q_NQ, SW_NP_NQ
    } t_sw;
    typedef enum logic [2:0] {ST_NONE, ST_IN, ST_T, ST_FULL, ST_RES} t_st_sel;

    typedef struct packed {
        t_rd_sel rd_sel;
        t_ew     ew;
        t_lw     lw;
        t_sw     sw;
        t_st_sel st_sel;
        logic    load_in;
        logic    set_t;
        logic    set_p_node;
        logic    set_q_t;
        logic    alloc_np;
        logic    alloc_nq;
        logic    k_inc;
        logic    p_from_s;
        logic    q_from_e;
        logic    lenp_from_l;
        logic    set_res;
        logic    load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic cmd;
        logic node_ok;
        logic sym_ok;
        logic t_nz;
        logic l_is_next;
        logic room;
        logic e_zero;
        logic e_is_q;
        logic p_zero;
        logic k_last;
        logic clone;
        logic out_busy;
    } t_ctrl_stat;

endpackage

>>> rtl/generalized_suffix_automaton.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generalized_suffix_automaton
// Builds a generalized suffix automaton in on-chip node tables and answers
// node queries.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Word
//  input    i_in_valid / o_in_ready   i_cmd, i_node, i_symbol
//  output   o_out_valid / i_out_ready o_result_node, o_node_length,
//                                     o_node_suffix, o_nodes_used, o_full_error
//
// A query is answered after one read of the node tables, and an extend that
// hits a solid transition after a second read for its target. An extend that
// allocates also clears the new node's edges, steps along suffix links in
// each walk, checks the target, copies and links a cloned node and reads the
// result back, since every table access goes through the single read port of
// each node table. After reset the block prepares the root node, with
// o_in_ready low. One word is worked on at a time; a finished word waits in
// the staging registers while the output register is stalled, and the next
// input word is taken only once it has moved into the output register.
// ----------------------------------------------------------------------------
module generalized_suffix_automaton
    import gsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic                    i_cmd,
    input  logic [NODE_W-1:0]       i_node,
    input  logic [SYM_W-1:0]        i_symbol,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [NODE_W-1:0]       o_result_node,
    output logic signed [LEN_W-1:0] o_node_length,
    output logic [NODE_W-1:0]       o_node_suffix,
    output logic [CNT_W-1:0]        o_nodes_used,
    output logic                    o_full_error
);
    t_ctrl_cmd  ctrl_cmd;
    t_ctrl_stat ctrl_stat;

    // The controller walks suffix links and clones; the datapath owns tables.
    gsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (ctrl_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (ctrl_cmd)
    );

    gsa_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_stat        (ctrl_stat),
        .i_cmd_bit     (i_cmd),
        .i_node        (i_node),
        .i_symbol      (i_symbol),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_result_node (o_result_node),
        .o_node_length (o_node_length),
        .o_node_suffix (o_node_suffix),
        .o_nodes_used  (o_nodes_used),
        .o_full_error  (o_full_error)
    );
endmodule

>>> rtl/gsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/gsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_ctrl
// Sequencer for reset fill, lookups, suffix-link walks and node cloning.
// ----------------------------------------------------------------------------
module gsa_ctrl
    import gsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_ctrl_stat i_stat,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:    if (i_stat.k_last) n_state = S_IDLE;
            S_IDLE:    if (i_in_valid) n_state = S_RD_IN;
            S_RD_IN:   n_state = S_CHK_IN;
            S_CHK_IN: begin
                if (i_stat.cmd == CMD_QUERY || !i_stat.node_ok || !i_stat.sym_ok) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD_T;
                end
            end
            S_RD_T:    n_state = S_CHK_T;
            S_CHK_T: begin
                priority if (i_stat.t_nz && i_stat.l_is_next) n_state = S_OUT;
                else if (!i_stat.room) n_state = S_OUT;
                else if (i_stat.t_nz) n_state = S_Q_RD;
                else n_state = S_CLR;
            end
            S_CLR:     if (i_stat.k_last) n_state = S_L1_RD;
            S_L1_RD:   n_state = S_L1_CHK;
            S_L1_CHK: begin
                priority if (i_stat.e_zero) n_state = S_L1_RD;
                else if (i_stat.p_zero) n_state = S_RES_RD;
                else n_state = S_Q_RD;
            end
            S_Q_RD:    n_state = S_Q_CHK;
            S_Q_CHK:   n_state = i_stat.l_is_next ? S_RES_RD : S_COPY_RD;
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: n_state = i_stat.k_last ? S_FIX1 : S_COPY_RD;
            S_FIX1:    n_state = S_FIX2;
            S_FIX2:    n_state = S_L2_RD;
            S_L2_RD:   n_state = i_stat.p_zero ? S_RES_RD : S_L2_CHK;
            S_L2_CHK:  n_state = i_stat.e_is_q ? S_L2_RD : S_RES_RD;
            S_RES_RD:  n_state = S_RES_CHK;
            S_RES_CHK: n_state = S_OUT;
            S_OUT:     if (!i_stat.out_busy) n_state = S_IDLE;
            default:   n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_NODE;
        o_cmd.ew     = EW_NONE;
        o_cmd.lw     = LW_NONE;
        o_cmd.sw     = SW_NONE;
        o_cmd.st_sel = ST_NONE;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.ew    = EW_CLR;
                o_cmd.lw    = LW_INIT;
                o_cmd.sw    = SW_INIT;
                o_cmd.k_inc = 1'b1;
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = 1'b1;
            end
            S_RD_IN: o_cmd.rd_sel = RD_NODE;
            S_CHK_IN: begin
                o_cmd.set_t = 1'b1;
                if (i_stat.cmd == CMD_QUERY || !i_stat.node_ok || !i_stat.sym_ok) begin
                    o_cmd.st_sel = ST_IN;
                end
            end
            S_RD_T: o_cmd.rd_sel = RD_T;
            S_CHK_T: begin
                priority if (i_stat.t_nz && i_stat.l_is_next) begin
                    o_cmd.st_sel = ST_T;
                end else if (!i_stat.room) begin
                    o_cmd.st_sel = ST_FULL;
                end else if (i_stat.t_nz) begin
                    o_cmd.set_p_node = 1'b1;
                    o_cmd.set_q_t    = 1'b1;
                end else begin
                    o_cmd.set_p_node = 1'b1;
                    o_cmd.alloc_np   = 1'b1;
                end
            end
            S_CLR: begin
                o_cmd.ew    = EW_CLR;
                o_cmd.lw    = LW_NP;
                o_cmd.k_inc = 1'b1;
            end
            S_L1_RD: o_cmd.rd_sel = RD_P;
            S_L1_CHK: begin
                priority if (i_stat.e_zero) begin
                    o_cmd.ew       = EW_LINK1;
                    o_cmd.p_from_s = 1'b1;
                end else if (i_stat.p_zero) begin
                    o_cmd.sw      = SW_NP_ONE;
                    o_cmd.set_res = 1'b1;
                end else begin
                    o_cmd.q_from_e    = 1'b1;
                    o_cmd.lenp_from_l = 1'b1;
                end
            end
            S_Q_RD: o_cmd.rd_sel = RD_Q;
            S_Q_CHK: begin
                if (i_stat.l_is_next) begin
                    o_cmd.sw      = SW_NP_Q;
                    o_cmd.set_res = 1'b1;
                end else begin
                    o_cmd.sw       = SW_NQ_SQ;
                    o_cmd.alloc_nq = 1'b1;
                end
            end
            S_COPY_RD: o_cmd.rd_sel = RD_Q;
            S_COPY_WR: begin
                o_cmd.ew    = EW_COPY;
                o_cmd.k_inc = 1'b1;
            end
            S_FIX1: begin
                o_cmd.lw = LW_NQ;
                o_cmd.sw = SW_Q_NQ;
            end
            S_FIX2: if (!i_stat.clone) o_cmd.sw = SW_NP_NQ;
            S_L2_RD: begin
                o_cmd.rd_sel = RD_P;
                if (i_stat.p_zero) o_cmd.set_res = 1'b1;
            end
            S_L2_CHK: begin
                if (i_stat.e_is_q) begin
                    o_cmd.ew       = EW_LINK2;
                    o_cmd.p_from_s = 1'b1;
                end else begin
                    o_cmd.set_res = 1'b1;
                end
            end
            S_RES_RD:  o_cmd.rd_sel = RD_RES;
            S_RES_CHK: o_cmd.st_sel = ST_RES;
            S_OUT:     o_cmd.load_out = !i_stat.out_busy;
            default: ;
        endcase
    end
endmodule

>>> rtl/gsa_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_dpath
// Node tables, working registers and the output word register.
// ----------------------------------------------------------------------------
module gsa_dpath
    import gsa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl_cmd               i_cmd,
    output t_ctrl_stat              o_stat,
    input  logic                    i_cmd_bit,
    input  logic [NODE_W-1:0]       i_node,
    input  logic [SYM_W-1:0]        i_symbol,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [NODE_W-1:0]       o_result_node,
    output logic signed [LEN_W-1:0] o_node_length,
    output logic [NODE_W-1:0]       o_node_suffix,
    output logic [CNT_W-1:0]        o_nodes_used,
    output logic                    o_full_error
);
    logic                    r_cmd;
    logic [NODE_W-1:0]       r_node, r_t, r_p, r_q, r_np, r_nq, r_res;
    logic [SYM_W-1:0]        r_sym, r_k;
    logic signed [LEN_W-1:0] r_lenp;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_clone, r_zero;
    logic [NODE_W-1:0]       r_st_res, r_st_suf;
    logic signed [LEN_W-1:0] r_st_len;
    logic                    r_st_full;
    logic                    r_ovalid;
    logic [NODE_W-1:0]       r_o_res, r_o_suf;
    logic signed [LEN_W-1:0] r_o_len;
    logic [CNT_W-1:0]        r_o_cnt;
    logic                    r_o_full;

    logic [NODE_W-1:0]       rd_node;
    logic [SYM_W-1:0]        rd_sym;
    logic [EADDR_W-1:0]      e_raddr, e_waddr;
    logic [NODE_W-1:0]       e_wdata, e_rraw, e_data;
    logic                    e_we, l_we, s_we;
    logic [NODE_W-1:0]       l_waddr, s_waddr, s_wdata, s_rraw, s_data;
    logic [LEN_W-1:0]        l_wdata, l_rraw;
    logic signed [LEN_W-1:0] l_data, lenp_inc;
    logic [NODE_W-1:0]       w_node;
    logic [SYM_W-1:0]        w_sym;
    logic                    out_busy;

    function automatic logic [EADDR_W-1:0] edge_addr(logic [NODE_W-1:0] n,
                                                     logic [SYM_W-1:0] s);
        edge_addr = EADDR_W'(n) * EADDR_W'(SYMBOLS) + EADDR_W'(s);
    endfunction

    // Read address selection, shared by all three tables.
    always_comb begin
        rd_node = r_node;
        rd_sym  = r_sym;
        unique case (i_cmd.rd_sel)
            RD_NODE: begin rd_node = r_node; rd_sym = r_sym; end
            RD_T:    rd_node = r_t;
            RD_P:    begin rd_node = r_p; rd_sym = r_sym; end
            RD_Q:    begin rd_node = r_q; rd_sym = r_k; end
            RD_RES:  rd_node = r_res;
            default: ;
        endcase
    end
    assign e_raddr = edge_addr(rd_node, rd_sym);

    // Node 0 is the sentinel and never written: its fields come from constants.
    assign e_data   = r_zero ? NODE_W'(1) : e_rraw;
    assign l_data   = r_zero ? -LEN_W'(1) : $signed(l_rraw);
    assign s_data   = r_zero ? '0 : s_rraw;
    assign lenp_inc = r_lenp + LEN_W'(1);

    always_comb begin
        e_we   = 1'b1;
        w_node = r_np;
        w_sym  = r_k;
        e_wdata = '0;
        unique case (i_cmd.ew)
            EW_NONE:  e_we = 1'b0;
            EW_CLR:   begin w_node = r_np; w_sym = r_k; end
            EW_LINK1: begin w_node = r_p; w_sym = r_sym; e_wdata = r_np; end
            EW_COPY:  begin w_node = r_nq; w_sym = r_k; e_wdata = e_data; end
            EW_LINK2: begin w_node = r_p; w_sym = r_sym; e_wdata = r_nq; end
            default:  e_we = 1'b0;
        endcase
    end
    assign e_waddr = edge_addr(w_node, w_sym);

    always_comb begin
        l_we    = 1'b1;
        l_waddr = r_np;
        l_wdata = lenp_inc;
        unique case (i_cmd.lw)
            LW_NONE: l_we = 1'b0;
            LW_INIT: begin l_waddr = NODE_W'(1); l_wdata = '0; end
            LW_NP:   l_waddr = r_np;
            LW_NQ:   l_waddr = r_nq;
            default: l_we = 1'b0;
        endcase
    end

    always_comb begin
        s_we    = 1'b1;
        s_waddr = r_np;
        s_wdata = r_nq;
        unique case (i_cmd.sw)
            SW_NONE:   s_we = 1'b0;
            SW_INIT:   begin s_waddr = NODE_W'(1); s_wdata = '0; end
            SW_NP_ONE: begin s_waddr = r_np; s_wdata = NODE_W'(1); end
            SW_NP_Q:   begin s_waddr = r_np; s_wdata = r_q; end
            SW_NQ_SQ:  begin s_waddr = r_cnt[NODE_W-1:0]; s_wdata = s_data; end
            SW_Q_NQ:   begin s_waddr = r_q; s_wdata = r_nq; end
            SW_NP_NQ:  begin s_waddr = r_np; s_wdata = r_nq; end
            default:   s_we = 1'b0;
        endcase
    end

    gsa_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rraw)
    );
    gsa_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_len_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(rd_node), .o_rdata(l_rraw)
    );
    gsa_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_suf_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(rd_node), .o_rdata(s_rraw)
    );

    assign out_busy = r_ovalid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CNT_W'(2);
            r_np     <= NODE_W'(1);
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.alloc_np || i_cmd.alloc_nq) r_cnt <= r_cnt + CNT_W'(1);
            if (i_cmd.alloc_np) r_np <= r_cnt[NODE_W-1:0];
            if (i_cmd.k_inc) begin
                r_k <= o_stat.k_last ? '0 : r_k + SYM_W'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero <= (rd_node == '0);
        if (i_cmd.load_in) begin
            r_cmd  <= i_cmd_bit;
            r_node <= i_node;
            r_sym  <= i_symbol;
        end
        if (i_cmd.set_t) begin
            r_t    <= e_data;
            r_lenp <= l_data;
        end
        if (i_cmd.set_p_node) begin
            r_p     <= r_node;
            r_clone <= (r_t != '0);
        end
        if (i_cmd.set_q_t) r_q <= r_t;
        if (i_cmd.alloc_nq) r_nq <= r_cnt[NODE_W-1:0];
        if (i_cmd.p_from_s) r_p <= s_data;
        if (i_cmd.q_from_e) r_q <= e_data;
        if (i_cmd.lenp_from_l) r_lenp <= l_data;
        if (i_cmd.set_res) r_res <= r_clone ? r_nq : r_np;
        unique case (i_cmd.st_sel)
            ST_NONE: ;
            ST_IN: begin
                r_st_res  <= (r_cmd == CMD_QUERY && o_stat.node_ok && o_stat.sym_ok)
                             ? e_data : '0;
                r_st_len  <= (r_cmd == CMD_QUERY && o_stat.node_ok) ? l_data : '0;
                r_st_suf  <= (r_cmd == CMD_QUERY && o_stat.node_ok) ? s_data : '0;
                r_st_full <= 1'b0;
            end
            ST_T: begin
                r_st_res  <= r_t;
                r_st_len  <= l_data;
                r_st_suf  <= s_data;
                r_st_full <= 1'b0;
            end
            ST_FULL: begin
                r_st_res  <= '0;
                r_st_len  <= '0;
                r_st_suf  <= '0;
                r_st_full <= 1'b1;
            end
            ST_RES: begin
                r_st_res  <= r_res;
                r_st_len  <= l_data;
                r_st_suf  <= s_data;
                r_st_full <= 1'b0;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_o_res  <= r_st_res;
            r_o_len  <= r_st_len;
            r_o_suf  <= r_st_suf;
            r_o_cnt  <= r_cnt;
            r_o_full <= r_st_full;
        end
    end

    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.node_ok   = {1'b0, r_node} < r_cnt;
        o_stat.sym_ok    = r_sym < SYM_W'(SYMBOLS);
        o_stat.t_nz      = (r_t != '0);
        o_stat.l_is_next = (l_data == lenp_inc);
        o_stat.room      = ({1'b0, r_cnt} + (CNT_W+1)'(2)) <= (CNT_W+1)'(MAX_NODES);
        o_stat.e_zero    = (e_data == '0);
        o_stat.e_is_q    = (e_data == r_q);
        o_stat.p_zero    = (r_p == '0);
        o_stat.k_last    = (r_k == SYM_W'(SYMBOLS - 1));
        o_stat.clone     = r_clone;
        o_stat.out_busy  = out_busy;
    end

    assign o_out_valid   = r_ovalid;
    assign o_result_node = r_o_res;
    assign o_node_length = r_o_len;
    assign o_node_suffix = r_o_suf;
    assign o_nodes_used  = r_o_cnt;
    assign o_full_error  = r_o_full;
endmodule
